// ===== hw/rtl/dur_pkg.sv =====
package dur_pkg;

  localparam int unsigned SecW          = 64;
  localparam int unsigned OutSecW       = 63;
  localparam int unsigned NanoW         = 30;
  localparam int unsigned MultW         = 17;
  localparam int unsigned QuoBits       = 17;
  localparam int unsigned DivW          = 47;
  localparam int unsigned FracWeightW   = 27;
  localparam int unsigned FracPosW      = 4;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [FracPosW-1:0] FracDigits = 4'd9;
  localparam logic [NanoW-1:0]    NanoPerSec = 30'd1000000000;

  localparam logic [7:0] Char0   = 8'h30;
  localparam logic [7:0] Char9   = 8'h39;
  localparam logic [7:0] CharDot = 8'h2e;
  localparam logic [7:0] CharS   = 8'h73;
  localparam logic [7:0] CharM   = 8'h6d;
  localparam logic [7:0] CharH   = 8'h68;
  localparam logic [7:0] CharD   = 8'h64;

  typedef enum logic [1:0] {
    UnitSec  = 2'd0,
    UnitMin  = 2'd1,
    UnitHour = 2'd2,
    UnitDay  = 2'd3
  } unit_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } chr_t;

  typedef struct packed {
    logic [OutSecW-1:0] whole_seconds;
    logic [NanoW-1:0]   nano_part;
    logic               parse_error;
  } res_t;

  // one finished string, as the front leaves it
  typedef struct packed {
    logic [SecW-1:0]  sec;
    logic [NanoW-1:0] nano;
    logic             rnd;
    unit_e            unit;
    logic             err;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } entry_t;

  function automatic logic [MultW-1:0] unit_mult(unit_e u);
    logic [MultW-1:0] m;
    unique case (u)
      UnitSec:  m = 17'd1;
      UnitMin:  m = 17'd60;
      UnitHour: m = 17'd3600;
      UnitDay:  m = 17'd86400;
    endcase
    return m;
  endfunction

  function automatic logic [FracWeightW-1:0] frac_weight(logic [FracPosW-1:0] pos);
    logic [FracWeightW-1:0] w;
    unique case (pos)
      4'd0:    w = 27'd100000000;
      4'd1:    w = 27'd10000000;
      4'd2:    w = 27'd1000000;
      4'd3:    w = 27'd100000;
      4'd4:    w = 27'd10000;
      4'd5:    w = 27'd1000;
      4'd6:    w = 27'd100;
      4'd7:    w = 27'd10;
      4'd8:    w = 27'd1;
      default: w = 27'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/dur_stream_if.sv =====
interface dur_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dur_front.sv =====
module dur_front import dur_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  chr_t   data_i,
  output logic   ready_o,
  input  logic   full_i,
  output entry_t push_o
);

  typedef enum logic [4:0] {
    PhIntFirst  = 5'b00001,
    PhInt       = 5'b00010,
    PhFracFirst = 5'b00100,
    PhFrac      = 5'b01000,
    PhSuffix    = 5'b10000
  } phase_e;

  phase_e              phase_q, phase_d, phase_s;
  logic [SecW-1:0]     sec_q, sec_d, sec_s;
  logic [NanoW-1:0]    nano_q, nano_d, nano_s;
  logic [FracPosW-1:0] pos_q, pos_d, pos_s;
  logic                rnd_q, rnd_d, rnd_s;
  unit_e               unit_q, unit_d, unit_s;
  logic                err_q, err_d, err_s;

  logic                accept;
  logic                is_digit;
  logic [3:0]          digit;
  logic                sfx_hit;
  unit_e               sfx_unit;
  logic [SecW+3:0]     sec_wide;
  logic [NanoW:0]      frac_prod;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    is_digit = (data_i.char_code >= Char0) && (data_i.char_code <= Char9);
    digit    = is_digit ? data_i.char_code[3:0] : 4'd0;

    sfx_hit  = 1'b1;
    sfx_unit = UnitSec;
    unique case (data_i.char_code)
      CharS:   sfx_unit = UnitSec;
      CharM:   sfx_unit = UnitMin;
      CharH:   sfx_unit = UnitHour;
      CharD:   sfx_unit = UnitDay;
      default: sfx_hit = 1'b0;
    endcase

    // sec * 10 + digit, carry above bit 63 means overflow
    sec_wide  = ({4'b0, sec_q} << 3) + ({4'b0, sec_q} << 1) + (SecW+4)'(digit);
    frac_prod = (NanoW+1)'(digit) * (NanoW+1)'(frac_weight(pos_q));

    phase_s = phase_q;
    sec_s   = sec_q;
    nano_s  = nano_q;
    pos_s   = pos_q;
    rnd_s   = rnd_q;
    unit_s  = unit_q;
    err_s   = err_q;

    if (!err_q) begin
      unique case (phase_q)
        PhIntFirst: begin
          if (is_digit) begin
            sec_s   = SecW'(digit);
            phase_s = PhInt;
          end else begin
            err_s = 1'b1;
          end
        end
        PhInt: begin
          if (is_digit) begin
            if (sec_wide[SecW+3:SecW] != 4'd0) err_s = 1'b1;
            else sec_s = sec_wide[SecW-1:0];
          end else if (data_i.char_code == CharDot) begin
            phase_s = PhFracFirst;
          end else if (sfx_hit) begin
            unit_s  = sfx_unit;
            phase_s = PhSuffix;
          end else begin
            err_s = 1'b1;
          end
        end
        PhFracFirst, PhFrac: begin
          if (is_digit) begin
            phase_s = PhFrac;
            if (pos_q < FracDigits) begin
              nano_s = nano_q + frac_prod[NanoW-1:0];
              pos_s  = pos_q + 4'd1;
            end else if (digit != 4'd0) begin
              rnd_s = 1'b1;
            end
          end else if (sfx_hit && (phase_q == PhFrac)) begin
            unit_s  = sfx_unit;
            phase_s = PhSuffix;
          end else begin
            err_s = 1'b1;
          end
        end
        // nothing may follow a suffix; illegal codes land here too
        default: err_s = 1'b1;
      endcase
    end

    push_o.valid    = accept && data_i.last_char;
    push_o.rec.sec  = sec_s;
    push_o.rec.nano = nano_s;
    push_o.rec.rnd  = rnd_s;
    push_o.rec.unit = unit_s;
    push_o.rec.err  = err_s || (phase_s == PhIntFirst) || (phase_s == PhFracFirst);

    phase_d = phase_q;
    sec_d   = sec_q;
    nano_d  = nano_q;
    pos_d   = pos_q;
    rnd_d   = rnd_q;
    unit_d  = unit_q;
    err_d   = err_q;
    if (accept) begin
      if (data_i.last_char) begin
        phase_d = PhIntFirst;
        sec_d   = '0;
        nano_d  = '0;
        pos_d   = '0;
        rnd_d   = 1'b0;
        unit_d  = UnitSec;
        err_d   = 1'b0;
      end else begin
        phase_d = phase_s;
        sec_d   = sec_s;
        nano_d  = nano_s;
        pos_d   = pos_s;
        rnd_d   = rnd_s;
        unit_d  = unit_s;
        err_d   = err_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIntFirst;
      sec_q   <= '0;
      nano_q  <= '0;
      pos_q   <= '0;
      rnd_q   <= 1'b0;
      unit_q  <= UnitSec;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      sec_q   <= sec_d;
      nano_q  <= nano_d;
      pos_q   <= pos_d;
      rnd_q   <= rnd_d;
      unit_q  <= unit_d;
      err_q   <= err_d;
    end
  end

endmodule

// ===== hw/rtl/dur_queue.sv =====
module dur_queue import dur_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  entry_t push_i,
  output logic   full_o,
  output entry_t head_o,
  input  logic   pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rec_t            slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.rec   = slot_q[rd_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop)      cnt_d = cnt_q + CntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= push_i.rec;
  end

endmodule

// ===== hw/rtl/dur_back.sv =====
module dur_back import dur_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  entry_t head_i,
  output logic   pop_o,
  output logic   res_valid_o,
  output res_t   res_data_o,
  input  logic   res_ready_i
);

  localparam int unsigned HalfW  = SecW / 2;
  localparam int unsigned PartW  = HalfW + MultW;
  localparam int unsigned ProdW  = SecW + MultW;
  localparam int unsigned TopW   = 32;
  localparam int unsigned TopLsb = DivW - TopW;
  localparam int unsigned RecipW = 18;
  localparam int unsigned EstW   = TopW + RecipW;
  localparam int unsigned RemW   = NanoW + 1;

  // 2^47 / 10^9 rounded down; the carry estimated from the top 32 bits of the
  // scaled nanoseconds is never high and at most one low
  localparam logic [RecipW-1:0] NanoRecip = 18'd140737;

  logic                 en;

  // multiply stage
  logic                 v0_q;
  logic [PartW-1:0]     plo_q, plo_d;
  logic [PartW-1:0]     phi_q, phi_d;
  logic [DivW-1:0]      sn_q, sn_d;
  logic                 err0_q;
  logic [MultW-1:0]     mult;
  logic [NanoW-1:0]     nanos;

  // combine stage, with the carry estimate
  logic [ProdW-1:0]     prod;
  logic [EstW-1:0]      est;
  logic [OutSecW-1:0]   secb_q, secb_d;
  logic                 errb_q, errb_d;
  logic [DivW-1:0]      snb_q;
  logic [QuoBits-1:0]   qeb_q, qeb_d;

  // remainder stage
  logic [DivW-1:0]      rem_full;
  logic [OutSecW-1:0]   secc_q;
  logic                 errc_q;
  logic [QuoBits-1:0]   qec_q;
  logic [RemW-1:0]      remc_q, remc_d;

  // correction stage
  logic [OutSecW-1:0]   secd_q;
  logic                 errd_q;
  logic [QuoBits-1:0]   qd_q, qd_d;
  logic [NanoW-1:0]     remd_q, remd_d;

  logic [2:0]           dv_q;
  logic                 res_valid_q;
  res_t                 res_q, res_d;
  logic [SecW-1:0]      sum;
  logic                 fin_err;

  assign en    = !res_valid_q || res_ready_i;
  assign pop_o = en && head_i.valid;

  always_comb begin
    mult  = unit_mult(head_i.rec.unit);
    nanos = head_i.rec.nano + NanoW'(head_i.rec.rnd);
    plo_d = PartW'(head_i.rec.sec[HalfW-1:0]) * PartW'(mult);
    phi_d = PartW'(head_i.rec.sec[SecW-1:HalfW]) * PartW'(mult);
    sn_d  = DivW'(nanos) * DivW'(mult);
  end

  always_comb begin
    prod   = {phi_q, HalfW'(0)} + ProdW'(plo_q);
    secb_d = prod[OutSecW-1:0];
    errb_d = err0_q || (prod[ProdW-1:OutSecW] != '0);
    est    = EstW'(sn_q[DivW-1:TopLsb]) * EstW'(NanoRecip);
    qeb_d  = est[TopW +: QuoBits];
  end

  // remainder after the estimate lies below two seconds
  always_comb begin
    rem_full = snb_q - DivW'(qeb_q) * DivW'(NanoPerSec);
    remc_d   = rem_full[RemW-1:0];
  end

  always_comb begin
    if (remc_q >= RemW'(NanoPerSec)) begin
      qd_d   = qec_q + QuoBits'(1);
      remd_d = NanoW'(remc_q - RemW'(NanoPerSec));
    end else begin
      qd_d   = qec_q;
      remd_d = remc_q[NanoW-1:0];
    end
  end

  // add the carried seconds, then zero the result on any error
  always_comb begin
    sum     = {1'b0, secd_q} + SecW'(qd_q);
    fin_err = errd_q || sum[SecW-1];
    res_d.parse_error   = fin_err;
    res_d.whole_seconds = fin_err ? '0 : sum[OutSecW-1:0];
    res_d.nano_part     = fin_err ? '0 : remd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      dv_q        <= '0;
      res_valid_q <= 1'b0;
    end else if (en) begin
      v0_q        <= head_i.valid;
      dv_q        <= {dv_q[1:0], v0_q};
      res_valid_q <= dv_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      sn_q   <= sn_d;
      err0_q <= head_i.rec.err;
      secb_q <= secb_d;
      errb_q <= errb_d;
      snb_q  <= sn_q;
      qeb_q  <= qeb_d;
      secc_q <= secb_q;
      errc_q <= errb_q;
      qec_q  <= qeb_q;
      remc_q <= remc_d;
      secd_q <= secc_q;
      errd_q <= errc_q;
      qd_q   <= qd_d;
      remd_q <= remd_d;
      res_q  <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_q;

endmodule

// ===== hw/rtl/duration_string_parser.sv =====
// Parses a decimal duration such as "12.5h" handed in one ASCII byte per request, the final
// byte flagged, and returns whole seconds, a nanosecond remainder and an error flag for each
// string. Bytes are taken one per cycle while the queue has room; a new string may start the
// cycle after the previous one ends. Once its final byte is accepted, a string enters the small
// queue, which hands it to the multiply stage; then one stage combines the seconds product and
// estimates the carried seconds by a reciprocal multiply, one stage forms the remainder, one
// stage corrects the estimate by at most one, and the output register holds the result.
// Output back-pressure stalls the whole result pipeline; once the queue behind it fills, the
// byte input drops ready.
module duration_string_parser import dur_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input logic         clk_i,
  input logic         rst_ni,
  dur_stream_if.sink   chr_i,
  dur_stream_if.source res_o
);

  entry_t push;
  entry_t head;
  logic   full;
  logic   pop;
  chr_t   chr_data;
  res_t   res_data;
  logic   res_valid;

  assign chr_data = chr_i.data;

  dur_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chr_i.valid),
    .data_i  (chr_data),
    .ready_o (chr_i.ready),
    .full_i  (full),
    .push_o  (push)
  );

  dur_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  dur_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .res_ready_i (res_o.ready)
  );

  assign res_o.valid = res_valid;
  assign res_o.data  = res_data;

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !full)
    else $error("finished string pushed into a full queue");

  a_nano_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res_data.nano_part < NanoPerSec))
    else $error("nanosecond remainder not below one second");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_data.parse_error) |->
      ((res_data.whole_seconds == '0) && (res_data.nano_part == '0)))
    else $error("error result carries a nonzero duration");

  a_pop_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_o.ready) |-> !pop)
    else $error("queue popped while result pipeline is stalled");

endmodule

// ===== test/tb.sv =====
module tb import dur_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit [63:0] MaxSec    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam bit [63:0] MaxAccum  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam bit [63:0] NsPerSec  = 64'd1000000000;
  localparam int        DrainWait = 40;

  class dur_scoreboard;
    typedef enum logic [2:0] {
      PhIntFirst,
      PhInt,
      PhFracFirst,
      PhFrac,
      PhSuffix
    } phase_e;

    phase_e      phase;
    bit [63:0]   sec_sum;
    bit [29:0]   nano_sum;
    bit [3:0]    frac_cnt;
    bit          round_up;
    unit_e       unit;
    bit          broken;
    res_t        pending[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    static function bit [63:0] secs_per(unit_e u);
      case (u)
        UnitMin:  return 64'd60;
        UnitHour: return 64'd3600;
        UnitDay:  return 64'd86400;
        default:  return 64'd1;
      endcase
    endfunction

    function void restart();
      phase    = PhIntFirst;
      sec_sum  = '0;
      nano_sum = '0;
      frac_cnt = '0;
      round_up = 1'b0;
      unit     = UnitSec;
      broken   = 1'b0;
    endfunction

    function void add_fraction(bit [3:0] d);
      bit [29:0] weight;
      weight = 30'd1;
      if (frac_cnt < 4'd9) begin
        repeat (8 - frac_cnt) weight = weight * 30'd10;
        nano_sum = nano_sum + d * weight;
        frac_cnt++;
      end else if (d != 0) begin
        round_up = 1'b1;
      end
    endfunction

    function void parse_char(bit [7:0] c);
      bit        is_dig;
      bit [3:0]  d;
      bit        is_sfx;
      unit_e     u;
      bit [67:0] wide;
      is_dig = (c >= Char0) && (c <= Char9);
      d      = is_dig ? 4'(c - Char0) : 4'd0;
      is_sfx = 1'b1;
      case (c)
        CharS:   u = UnitSec;
        CharM:   u = UnitMin;
        CharH:   u = UnitHour;
        CharD:   u = UnitDay;
        default: begin
          u      = UnitSec;
          is_sfx = 1'b0;
        end
      endcase
      case (phase)
        PhIntFirst: begin
          if (is_dig) begin
            sec_sum = 64'(d);
            phase   = PhInt;
          end else begin
            broken = 1'b1;
          end
        end
        PhInt: begin
          if (is_dig) begin
            wide = 68'(sec_sum) * 68'd10 + 68'(d);
            if (wide[67:64] != 0) broken = 1'b1;
            else sec_sum = wide[63:0];
          end else if (c == CharDot) begin
            phase = PhFracFirst;
          end else if (is_sfx) begin
            unit  = u;
            phase = PhSuffix;
          end else begin
            broken = 1'b1;
          end
        end
        PhFracFirst: begin
          if (is_dig) begin
            add_fraction(d);
            phase = PhFrac;
          end else begin
            broken = 1'b1;
          end
        end
        PhFrac: begin
          if (is_dig) begin
            add_fraction(d);
          end else if (is_sfx) begin
            unit  = u;
            phase = PhSuffix;
          end else begin
            broken = 1'b1;
          end
        end
        default: broken = 1'b1;
      endcase
    endfunction

    function void note_request(bit [7:0] c, bit last);
      bit        fail;
      bit [63:0] s, n, m, scaled;
      res_t      exp;
      if (!broken) parse_char(c);
      if (!last) return;
      fail = broken || phase == PhIntFirst || phase == PhFracFirst;
      s = '0;
      n = '0;
      if (!fail) begin
        m = secs_per(unit);
        s = sec_sum;
        n = 64'(nano_sum) + 64'(round_up);
        if (s > MaxSec / m) begin
          fail = 1'b1;
        end else begin
          s = s * m;
          if (n != 0) begin
            scaled = n * m;
            s = s + scaled / NsPerSec;
            n = scaled % NsPerSec;
            if (s > MaxSec) fail = 1'b1;
          end
        end
      end
      if (fail) begin
        s = '0;
        n = '0;
      end
      exp.whole_seconds = s[62:0];
      exp.nano_part     = n[29:0];
      exp.parse_error   = fail;
      pending.push_back(exp);
      restart();
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(res_t got);
      res_t exp;
      if (pending.size() == 0) begin
        report("result with no string pending");
        return;
      end
      exp = pending.pop_front();
      if (got.whole_seconds !== exp.whole_seconds)
        report($sformatf("whole_seconds got %0d expected %0d",
                         got.whole_seconds, exp.whole_seconds));
      if (got.nano_part !== exp.nano_part)
        report($sformatf("nano_part got %0d expected %0d", got.nano_part, exp.nano_part));
      if (got.parse_error !== exp.parse_error)
        report($sformatf("parse_error got %0b expected %0b",
                         got.parse_error, exp.parse_error));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dur_stream_if #(.T(chr_t)) chr_if ();
  dur_stream_if #(.T(res_t)) res_if ();

  duration_string_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .chr_i  (chr_if),
    .res_o  (res_if)
  );

  dur_scoreboard sb = new();
  bit [7:0]      text[$];
  int unsigned   sent = 0;
  int unsigned   idle_odds = 0;
  bit            calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit [7:0] suffix_of(unit_e u);
    case (u)
      UnitMin:  return CharM;
      UnitHour: return CharH;
      UnitDay:  return CharD;
      default:  return CharS;
    endcase
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endfunction

  function automatic void add_digits(int unsigned n);
    repeat (n) text.push_back(Char0 + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void add_dec(bit [63:0] v);
    add_str($sformatf("%0d", v));
  endfunction

  function automatic void add_wellformed();
    add_digits($urandom_range(0, 9) == 0 ? $urandom_range(7, 20) : $urandom_range(1, 4));
    if ($urandom_range(0, 1) != 0) begin
      text.push_back(CharDot);
      add_digits($urandom_range(0, 4) == 0 ? $urandom_range(10, 13) : $urandom_range(1, 9));
    end
    if ($urandom_range(0, 2) != 0) text.push_back(suffix_of(unit_e'($urandom_range(0, 3))));
  endfunction

  task automatic send_char(bit [7:0] c, bit last);
    // idle the request side for a short burst now and then
    if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      chr_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    chr_if.valid <= 1'b1;
    chr_if.data  <= '{char_code: c, last_char: last};
    do @(posedge clk_i); while (!chr_if.ready);
    sb.note_request(c, last);
    sent++;
  endtask

  task automatic send_text();
    idle_odds = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 8);
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
    text.delete();
  endtask

  initial begin : drive
    unit_e       u;
    int unsigned pos;
    chr_if.valid <= 1'b0;
    chr_if.data  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // leading non-digit at the top of the byte range
    text.push_back(8'hff);
    send_text();
    add_str("0");
    send_text();
    add_str("1.");
    send_text();
    add_str("1s5");
    send_text();
    // zero byte as the final byte of a string
    add_str("1");
    text.push_back(8'h00);
    send_text();
    add_str("7.5m");
    send_text();
    add_str("2h");
    send_text();
    add_str("3d");
    send_text();
    add_str("9s");
    send_text();

    while (sent < 720) begin
      if (sent >= 620) calm = 1'b1;
      u = unit_e'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: add_wellformed();
        5: begin
          case ($urandom_range(0, 3))
            0: begin
              // integer accumulation right at the 64-bit limit
              add_dec(MaxAccum - 64'($urandom_range(0, 12)));
              if ($urandom_range(0, 1) != 0) add_digits(1);
            end
            1: begin
              add_dec(MaxSec / dur_scoreboard::secs_per(u) + 64'($urandom_range(0, 4)) - 64'd2);
              if ($urandom_range(0, 1) != 0) begin
                text.push_back(CharDot);
                add_digits($urandom_range(1, 10));
              end
              text.push_back(suffix_of(u));
            end
            2: begin
              // rounding carry pushes the scaled seconds over the edge
              add_dec(MaxSec / dur_scoreboard::secs_per(u));
              add_str(".9999999999");
              text.push_back(suffix_of(u));
            end
            default: begin
              add_dec({$urandom, $urandom});
              if ($urandom_range(0, 1) != 0) text.push_back(suffix_of(u));
            end
          endcase
        end
        6: begin
          // nine nines plus a nonzero tail digit
          add_digits($urandom_range(1, 3));
          add_str(".999999999");
          text.push_back(Char0 + 8'($urandom_range(1, 9)));
          add_digits($urandom_range(0, 2));
          if ($urandom_range(0, 1) != 0) text.push_back(suffix_of(u));
        end
        7, 8: begin
          case ($urandom_range(0, 3))
            0: begin
              add_wellformed();
              pos = $urandom_range(0, text.size() - 1);
              text[pos] = 8'($urandom_range(0, 255));
            end
            1: begin
              add_digits($urandom_range(1, 3));
              text.push_back(CharDot);
            end
            2: begin
              add_digits($urandom_range(1, 3));
              text.push_back(suffix_of(u));
              text.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
              text.push_back(8'($urandom_range(0, 255)));
              add_wellformed();
            end
          endcase
        end
        default: repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
      endcase
      send_text();
    end

    chr_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin : collect
    int unsigned hold;
    int unsigned odds;
    hold = 0;
    odds = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) sb.check_result(res_if.data);
      if ($urandom_range(0, 63) == 0) odds = $urandom_range(0, 3);
      if (hold == 0 && !calm && odds != 0 && $urandom_range(1, 4 * odds) == 1)
        hold = $urandom_range(1, 6);
      // hold off results for the rest of the burst
      if (hold != 0) begin
        res_if.ready <= 1'b0;
        hold--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
